FILE: hdl/lkvc_pkg.sv
// Shared types and constants for the LRU key-value cache core.
// No dependencies.
`default_nettype none

package lkvc_pkg;

   localparam int KEY_W   = 32;
   localparam int VALUE_W = 32;
   localparam int CAP_W   = 5;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
   localparam logic [CAP_W-1:0] CAP_MIN   = 5'd1;

   localparam logic MODE_GET = 1'b0;
   localparam logic MODE_PUT = 1'b1;

   typedef struct packed {
      logic               found;
      logic [VALUE_W-1:0] read_value;
      logic               evicted;
   } rsp_type;

endpackage

`default_nettype wire

FILE: hdl/lru_key_value_cache_core.sv
// Top level of the LRU key-value cache: capacity register and sequencer.
// Depends on lkvc_pkg, lkvc_sequencer.
//
//   channel   handshake              payload
//   request   start & !busy          req_mode, req_lookup_key, req_write_value
//   response  rsp_valid (1 cycle)    rsp_found, rsp_read_value, rsp_evicted
//   config    csr_valid & csr_ready  csr_data (capacity_in_use)
//
// A get miss strobes after one RAM scan pass; a hit or put takes one RAM scan pass
// and one rank rewrite pass, one entry per cycle.
// busy drops in the strobe cycle, so the next transaction can start there.
// Synchronous reset empties the cache; no clearing pass (valid bits in flops).
// The receiver cannot stall: each response is shown for one cycle only.
`default_nettype none

module lru_key_value_cache_core #(
   parameter int ENTRIES = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic                        req_mode,
   input  wire logic [lkvc_pkg::KEY_W-1:0]   req_lookup_key,
   input  wire logic [lkvc_pkg::VALUE_W-1:0] req_write_value,
   output logic                             rsp_valid,
   output logic                             rsp_found,
   output logic [lkvc_pkg::VALUE_W-1:0]      rsp_read_value,
   output logic                             rsp_evicted,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [lkvc_pkg::CAP_W-1:0]   csr_data
);

   logic [lkvc_pkg::CAP_W-1:0] cap_ff, cap_in;
   logic [lkvc_pkg::CAP_W-1:0] cap_limit;
   lkvc_pkg::rsp_type          rsp;

   assign csr_ready = 1'b1;
   assign cap_in    = (csr_valid && csr_ready) ? csr_data : cap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= lkvc_pkg::CAP_RESET;
      end else begin
         cap_ff <= cap_in;
      end
   end

   // zero capacity behaves as one
   assign cap_limit = (cap_ff == '0) ? lkvc_pkg::CAP_MIN : cap_ff;

   lkvc_sequencer #(
      .ENTRIES (ENTRIES)
   ) u_seq (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_mode        (req_mode),
      .req_lookup_key  (req_lookup_key),
      .req_write_value (req_write_value),
      .cap_limit       (cap_limit),
      .rsp_valid       (rsp_valid),
      .rsp             (rsp)
   );

   assign rsp_found      = rsp.found;
   assign rsp_read_value = rsp.read_value;
   assign rsp_evicted    = rsp.evicted;

endmodule

`default_nettype wire

FILE: hdl/lkvc_entry_ram.sv
// Entry store: simple dual-port synchronous RAM, one write and one registered read per cycle.
// No dependencies.
`default_nettype none

module lkvc_entry_ram #(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4,
   parameter int WORD_W = 68
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WORD_W-1:0] wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WORD_W-1:0] rd_data
);

   logic [WORD_W-1:0] mem [DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hdl/lkvc_sequencer.sv
// Lookup/update sequencer: scans the entry RAM, picks hit, free or LRU slot;
// a hit or put reranks in a second pass. Depends on lkvc_pkg, lkvc_entry_ram.
`default_nettype none

module lkvc_sequencer #(
   parameter int ENTRIES = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic                        req_mode,
   input  wire logic [lkvc_pkg::KEY_W-1:0]   req_lookup_key,
   input  wire logic [lkvc_pkg::VALUE_W-1:0] req_write_value,
   input  wire logic [lkvc_pkg::CAP_W-1:0]   cap_limit,
   output logic                             rsp_valid,
   output lkvc_pkg::rsp_type                rsp
);

   localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int RANK_W = IDX_W;
   localparam int CNT_W  = $clog2(ENTRIES + 1);
   localparam int WORD_W = lkvc_pkg::KEY_W + lkvc_pkg::VALUE_W + RANK_W;
   localparam int CMP_W  = (CNT_W > lkvc_pkg::CAP_W) ? CNT_W : lkvc_pkg::CAP_W;
   localparam logic [CNT_W-1:0] CNT_END = CNT_W'(ENTRIES);

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_UPDATE} state_type;

   state_type                     state_ff, state_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic                          pvld_ff, pvld_in;
   logic [IDX_W-1:0]              pidx_ff, pidx_in;
   logic                          mode_ff, mode_in;
   logic [lkvc_pkg::KEY_W-1:0]    key_ff, key_in;
   logic [lkvc_pkg::VALUE_W-1:0]  value_ff, value_in;
   logic                          hit_ff, hit_in;
   logic [IDX_W-1:0]              hit_idx_ff, hit_idx_in;
   logic [RANK_W-1:0]             hit_rank_ff, hit_rank_in;
   logic [lkvc_pkg::VALUE_W-1:0]  hit_val_ff, hit_val_in;
   logic                          lru_ff, lru_in;
   logic [IDX_W-1:0]              lru_idx_ff, lru_idx_in;
   logic [RANK_W-1:0]             lru_rank_ff, lru_rank_in;
   logic                          free_ff, free_in;
   logic [IDX_W-1:0]              free_idx_ff, free_idx_in;
   logic [IDX_W-1:0]              tgt_idx_ff, tgt_idx_in;
   logic                          ins_ff, ins_in;
   logic                          ev_ff, ev_in;
   logic [ENTRIES-1:0]            valid_ff, valid_in;
   logic [CNT_W-1:0]              occ_ff, occ_in;
   lkvc_pkg::rsp_type             rsp_ff, rsp_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   logic                          issue;
   logic                          occ_full;
   logic [IDX_W-1:0]              rd_addr;
   logic [WORD_W-1:0]             rd_data;
   logic                          wr_en;
   logic [WORD_W-1:0]             wr_data;
   logic [lkvc_pkg::KEY_W-1:0]    rd_key;
   logic [lkvc_pkg::VALUE_W-1:0]  rd_val;
   logic [RANK_W-1:0]             rd_rank;
   logic                          cur_valid;
   logic                          rank_inc;

   lkvc_entry_ram #(
      .DEPTH  (ENTRIES),
      .ADDR_W (IDX_W),
      .WORD_W (WORD_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (pidx_ff),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_key    = rd_data[WORD_W-1 -: lkvc_pkg::KEY_W];
   assign rd_val    = rd_data[RANK_W +: lkvc_pkg::VALUE_W];
   assign rd_rank   = rd_data[RANK_W-1:0];
   assign cur_valid = valid_ff[pidx_ff];
   assign issue     = (state_ff != ST_IDLE) && (cnt_ff != CNT_END);
   assign rd_addr   = issue ? cnt_ff[IDX_W-1:0] : '0;
   assign occ_full  = (CMP_W'(occ_ff) >= CMP_W'(cap_limit)) || (occ_ff == CNT_END);
   assign rank_inc  = ins_ff || (rd_rank < hit_rank_ff);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = issue ? cnt_ff + CNT_W'(1) : cnt_ff;
      pvld_in      = issue;
      pidx_in      = cnt_ff[IDX_W-1:0];
      mode_in      = mode_ff;
      key_in       = key_ff;
      value_in     = value_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      hit_rank_in  = hit_rank_ff;
      hit_val_in   = hit_val_ff;
      lru_in       = lru_ff;
      lru_idx_in   = lru_idx_ff;
      lru_rank_in  = lru_rank_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      tgt_idx_in   = tgt_idx_ff;
      ins_in       = ins_ff;
      ev_in        = ev_ff;
      valid_in     = valid_ff;
      occ_in       = occ_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      wr_en        = 1'b0;
      wr_data      = rd_data;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               mode_in  = req_mode;
               key_in   = req_lookup_key;
               value_in = req_write_value;
               hit_in   = 1'b0;
               lru_in   = 1'b0;
               free_in  = 1'b0;
               cnt_in   = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (pvld_ff) begin
               if (cur_valid && (rd_key == key_ff) && !hit_ff) begin
                  hit_in      = 1'b1;
                  hit_idx_in  = pidx_ff;
                  hit_rank_in = rd_rank;
                  hit_val_in  = rd_val;
               end
               if (cur_valid && (!lru_ff || (rd_rank > lru_rank_ff))) begin
                  lru_in      = 1'b1;
                  lru_idx_in  = pidx_ff;
                  lru_rank_in = rd_rank;
               end
               if (!cur_valid && !free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = pidx_ff;
               end
            end else if (cnt_ff == CNT_END) begin
               cnt_in = '0;
               if (hit_ff) begin
                  tgt_idx_in        = hit_idx_ff;
                  ins_in            = 1'b0;
                  ev_in             = 1'b0;
                  rsp_in.found      = 1'b1;
                  rsp_in.read_value = (mode_ff == lkvc_pkg::MODE_GET) ? hit_val_ff : '0;
                  rsp_in.evicted    = 1'b0;
                  state_in          = ST_UPDATE;
               end else if (mode_ff == lkvc_pkg::MODE_GET) begin
                  rsp_in       = '0;
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  ins_in            = 1'b1;
                  ev_in             = !(free_ff && !occ_full);
                  tgt_idx_in        = (free_ff && !occ_full) ? free_idx_ff : lru_idx_ff;
                  rsp_in.found      = 1'b0;
                  rsp_in.read_value = '0;
                  rsp_in.evicted    = !(free_ff && !occ_full);
                  state_in          = ST_UPDATE;
               end
            end
         end
         ST_UPDATE: begin
            if (pvld_ff) begin
               if (pidx_ff == tgt_idx_ff) begin
                  wr_en             = 1'b1;
                  wr_data           = {ins_ff ? key_ff : rd_key,
                                       (mode_ff == lkvc_pkg::MODE_PUT) ? value_ff : rd_val,
                                       {RANK_W{1'b0}}};
                  valid_in[pidx_ff] = 1'b1;
               end else if (cur_valid) begin
                  wr_en   = 1'b1;
                  wr_data = {rd_key, rd_val, rank_inc ? rd_rank + RANK_W'(1) : rd_rank};
               end
            end else if (cnt_ff == CNT_END) begin
               if (ins_ff && !ev_ff) begin
                  occ_in = occ_ff + CNT_W'(1);
               end
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         pvld_ff      <= 1'b0;
         valid_ff     <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pvld_ff      <= pvld_in;
         valid_ff     <= valid_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pidx_ff     <= pidx_in;
      mode_ff     <= mode_in;
      key_ff      <= key_in;
      value_ff    <= value_in;
      hit_ff      <= hit_in;
      hit_idx_ff  <= hit_idx_in;
      hit_rank_ff <= hit_rank_in;
      hit_val_ff  <= hit_val_in;
      lru_ff      <= lru_in;
      lru_idx_ff  <= lru_idx_in;
      lru_rank_ff <= lru_rank_in;
      free_ff     <= free_in;
      free_idx_ff <= free_idx_in;
      tgt_idx_ff  <= tgt_idx_in;
      ins_ff      <= ins_in;
      ev_ff       <= ev_in;
      rsp_ff      <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

`default_nettype wire
